/* rtl/hrtt_pkg.sv */
// Package: opcodes, kind codes and constants of the handle range translation table.
package hrtt_pkg;
	typedef enum logic [2:0] {
		OP_AUTO_ADD = 3'd0,
		OP_ADD      = 3'd1,
		OP_LOOKUP   = 3'd2,
		OP_REMOVE   = 3'd3,
		OP_REVERSE  = 3'd4,
		OP_PATCH    = 3'd5,
		OP_NOP_6    = 3'd6,
		OP_NOP_7    = 3'd7
	} op_t;

	localparam logic [3:0]  KIND_MEM      = 4'd0;
	localparam logic [3:0]  KIND_HOST_MEM = 4'd6;
	localparam logic [63:0] HANDLE_BASE   = 64'h0000_0000_1000_0000;
	localparam int          STAMP_W       = 48;

	// match modes of the entry compare unit
	typedef enum logic [1:0] {
		MODE_EXACT = 2'd0,
		MODE_RANGE = 2'd1,
		MODE_PTR   = 2'd2
	} mode_t;

	typedef struct packed {
		logic [3:0]  kind;
		mode_t       mode;
		logic [63:0] key;
	} match_req_t;
endpackage

/* rtl/hrtt_match.sv */
// Entry compare unit: decides whether one table entry matches the current search.
module hrtt_match (
	input  hrtt_pkg::match_req_t req,
	input  logic                 valid,
	input  logic [3:0]           kind,
	input  logic [63:0]          handle,
	input  logic [63:0]          pointer,
	input  logic [63:0]          size,
	output logic                 hit
);
	import hrtt_pkg::*;
	logic [63:0] diff;
	always_comb begin
		diff = req.key - handle;
		hit = 1'b0;
		if (valid && kind == req.kind) begin
			unique case (req.mode)
				MODE_EXACT: hit = (handle == req.key);
				MODE_RANGE: hit = (req.key >= handle) && (diff < size);
				MODE_PTR:   hit = (pointer == req.key);
				default:    hit = 1'b0;
			endcase
		end
	end
endmodule

/* rtl/handle_range_translation_table.sv */
// Top level of the handle range translation table.
// Each command walks the entry memory one entry a cycle through a single compare
// unit; the compare trails the registered read, and a last scan step drains it
// while the winner is fetched. The read state reads the chosen entry back and the
// finish state registers the result together with its strobe. busy is high from
// the accepting edge until the result strobe, so the next command can be accepted
// at the edge that ends the strobe. The result is shown for one cycle and cannot
// be stalled.
module handle_range_translation_table #(
	parameter int TABLE_ENTRIES = 64,
	parameter int NUM_KINDS     = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [3:0]  res_type,
	input  logic [63:0] key_value,
	input  logic [63:0] pointer_value,
	input  logic [63:0] region_size,
	input  logic        last_word,
	output logic        done,
	output logic [63:0] result_value,
	output logic        found,
	output logic        table_full,
	output logic        buffer_hit
);
	import hrtt_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_READ, S_FINISH} state_t;
	state_t state_q;

	// entry memory: fields read at one address, registered
	logic [3:0]         kind_mem    [TABLE_ENTRIES];
	logic [63:0]        handle_mem  [TABLE_ENTRIES];
	logic [63:0]        pointer_mem [TABLE_ENTRIES];
	logic [63:0]        size_mem    [TABLE_ENTRIES];
	logic [STAMP_W-1:0] stamp_mem   [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic [3:0]         rd_kind_q;
	logic [63:0]        rd_handle_q, rd_pointer_q, rd_size_q;
	logic [STAMP_W-1:0] rd_stamp_q;
	logic               rd_valid_q;

	// command registers
	logic [2:0]  op_q;
	logic [3:0]  kind_q;
	logic [63:0] key_q, ptr_q, size_q;
	logic        last_q;
	match_req_t  req_q;

	logic [CW-1:0] scan_q;     // address being read; one ahead of the compare
	logic          cmp_live_q; // a read result is waiting in rd_*_q
	logic [IW-1:0] cmp_idx_q;
	logic          best_ok_q;
	logic [IW-1:0] best_idx_q;
	logic [STAMP_W-1:0] best_stamp_q;
	logic          free_ok_q;
	logic [IW-1:0] free_idx_q;

	logic [63:0]        next_handle_q;
	logic [STAMP_W-1:0] next_stamp_q;
	logic               hit_sticky_q;

	logic          hit;
	logic [IW-1:0] rd_addr;

	hrtt_match u_match (
		.req     (req_q),
		.valid   (rd_valid_q),
		.kind    (rd_kind_q),
		.handle  (rd_handle_q),
		.pointer (rd_pointer_q),
		.size    (rd_size_q),
		.hit     (hit)
	);

	// address the memory: during the walk the scan counter, then the winner
	always_comb begin
		if (state_q == S_SCAN && scan_q < CW'(TABLE_ENTRIES))
			rd_addr = scan_q[IW-1:0];
		else
			rd_addr = best_idx_q;
	end

	always_ff @(posedge clk) begin
		rd_kind_q    <= kind_mem[rd_addr];
		rd_handle_q  <= handle_mem[rd_addr];
		rd_pointer_q <= pointer_mem[rd_addr];
		rd_size_q    <= size_mem[rd_addr];
		rd_stamp_q   <= stamp_mem[rd_addr];
	end

	// add: the store happens in the finish state when a free entry exists
	logic        is_add, do_store;
	logic [63:0] add_handle;
	always_comb begin
		is_add     = (op_q == OP_AUTO_ADD) || (op_q == OP_ADD);
		do_store   = (state_q == S_FINISH) && is_add && free_ok_q;
		add_handle = (op_q == OP_AUTO_ADD) ? next_handle_q + 64'd1 : key_q;
	end

	always_ff @(posedge clk) begin
		if (do_store) begin
			kind_mem[free_idx_q]    <= kind_q;
			handle_mem[free_idx_q]  <= add_handle;
			pointer_mem[free_idx_q] <= ptr_q;
			size_mem[free_idx_q]    <= size_q;
			stamp_mem[free_idx_q]   <= next_stamp_q;
		end
	end

	// result beat, formed from the walk and the winner read back
	logic [63:0] res_value;
	logic        res_found, res_full, res_bhit;
	always_comb begin
		res_value = '0;
		res_found = 1'b0;
		res_full  = 1'b0;
		res_bhit  = 1'b0;
		case (op_q)
			OP_AUTO_ADD, OP_ADD: begin
				if (free_ok_q) begin
					res_value = add_handle;
					res_found = 1'b1;
				end else
					res_full = 1'b1;
			end
			OP_LOOKUP: begin
				res_found = best_ok_q;
				if (best_ok_q)
					res_value = (req_q.mode == MODE_RANGE)
						? rd_pointer_q + (key_q - rd_handle_q) : rd_pointer_q;
			end
			OP_REMOVE: res_found = best_ok_q;
			OP_REVERSE: begin
				if (best_ok_q && ptr_q != 64'd0) begin
					res_found = 1'b1;
					res_value = rd_handle_q;
				end
			end
			OP_PATCH: begin
				res_found = best_ok_q;
				res_bhit  = best_ok_q || hit_sticky_q;
				res_value = best_ok_q ? rd_pointer_q + (key_q - rd_handle_q) : key_q;
			end
			default: ;
		endcase
	end

	logic bad_kind;
	always_comb bad_kind = (opcode <= OP_REVERSE) && (32'(res_type) >= NUM_KINDS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			busy          <= 1'b0;
			done          <= 1'b0;
			valid_q       <= '0;
			next_handle_q <= HANDLE_BASE;
			next_stamp_q  <= '0;
			hit_sticky_q  <= 1'b0;
			cmp_live_q    <= 1'b0;
			rd_valid_q    <= 1'b0;
		end else begin
			done       <= (state_q == S_FINISH);
			rd_valid_q <= (state_q == S_SCAN && scan_q < CW'(TABLE_ENTRIES))
				? valid_q[rd_addr] : 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						busy         <= 1'b1;
						state_q      <= S_SCAN;
						op_q         <= bad_kind ? OP_NOP_7 : opcode;
						kind_q       <= res_type;
						key_q        <= key_value;
						ptr_q        <= pointer_value;
						size_q       <= region_size;
						last_q       <= last_word;
						scan_q       <= '0;
						cmp_live_q   <= 1'b0;
						best_ok_q    <= 1'b0;
						free_ok_q    <= 1'b0;
						best_idx_q   <= '0;
						best_stamp_q <= '0;
						free_idx_q   <= '0;
						req_q.kind   <= (opcode == OP_PATCH) ? KIND_HOST_MEM : res_type;
						req_q.key    <= (opcode == OP_REVERSE) ? pointer_value : key_value;
						if (opcode == OP_REVERSE)
							req_q.mode <= MODE_PTR;
						else if (opcode == OP_PATCH || (opcode == OP_LOOKUP &&
							(res_type == KIND_MEM || res_type == KIND_HOST_MEM)))
							req_q.mode <= MODE_RANGE;
						else
							req_q.mode <= MODE_EXACT;
					end
				end
				S_SCAN: begin
					// advance the address, compare the entry read last cycle
					if (scan_q < CW'(TABLE_ENTRIES)) begin
						scan_q <= scan_q + CW'(1);
						cmp_idx_q <= scan_q[IW-1:0];
						if (!free_ok_q && !valid_q[scan_q[IW-1:0]]) begin
							free_ok_q  <= 1'b1;
							free_idx_q <= scan_q[IW-1:0];
						end
					end
					cmp_live_q <= scan_q < CW'(TABLE_ENTRIES);
					if (cmp_live_q && hit && (!best_ok_q || rd_stamp_q > best_stamp_q)) begin
						best_ok_q    <= 1'b1;
						best_idx_q   <= cmp_idx_q;
						best_stamp_q <= rd_stamp_q;
					end
					if (!(scan_q < CW'(TABLE_ENTRIES)) && !cmp_live_q)
						state_q <= S_READ;
				end
				S_READ: state_q <= S_FINISH; // winner comes back from memory
				S_FINISH: begin
					state_q      <= S_IDLE;
					busy         <= 1'b0;
					result_value <= res_value;
					found        <= res_found;
					table_full   <= res_full;
					buffer_hit   <= res_bhit;
					case (op_q)
						OP_AUTO_ADD, OP_ADD: begin
							if (free_ok_q) begin
								valid_q[free_idx_q] <= 1'b1;
								next_stamp_q <= next_stamp_q + STAMP_W'(1);
								if (op_q == OP_AUTO_ADD)
									next_handle_q <= add_handle +
										((kind_q == KIND_MEM) ? size_q : 64'd0);
							end
						end
						OP_REMOVE: begin
							if (best_ok_q) valid_q[best_idx_q] <= 1'b0;
						end
						OP_PATCH: begin
							hit_sticky_q <= last_q ? 1'b0 : (best_ok_q || hit_sticky_q);
						end
						default: ;
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* rtl/hrtt_checker.sv */
// Port-level checker for the handle range translation table, with its bind.
module hrtt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic found,
	input logic table_full
);
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted beat did not raise busy");
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		done && table_full |-> !found) else $error("full and found together");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(busy)) else $error("result without a command");
endmodule

bind handle_range_translation_table hrtt_checker u_hrtt_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.found(found), .table_full(table_full)
);
